@@ rtl/pcf_pkg.sv @@
// Shared types, codes and constants of the pointwise convolution core.
`timescale 1ns / 1ps

package pcf_pkg;

  // Fixed field widths
  localparam int unsigned CH_W        = 6;
  localparam int unsigned VAL_W       = 16;
  localparam int unsigned CNT_W       = 7;
  localparam int unsigned REQ_W       = 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 7;

  // Arithmetic
  localparam int unsigned DATA_WIDTH  = 16;
  localparam int unsigned FRAC_SHIFT  = 14;
  localparam int unsigned ACC_W       = 40;
  localparam int unsigned PROD_W      = 2 * VAL_W;
  localparam int unsigned CH_LIMIT    = 64;

  // Parameter defaults
  localparam int unsigned MAX_IN_CH_DEFAULT  = 64;
  localparam int unsigned MAX_OUT_CH_DEFAULT = 64;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_WEIGHT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_BIAS   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_PIXEL  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IN_CHANNELS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_CHANNELS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELU_ENABLE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_ENABLE  = 2'd3;

  // Operations queued for the back end
  typedef enum logic [1:0] {
    OP_WEIGHT  = 2'd0,
    OP_BIAS    = 2'd1,
    OP_PIXEL   = 2'd2,
    OP_COMPUTE = 2'd3
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic [CH_W-1:0]         oc;
    logic [CH_W-1:0]         ic;
    logic signed [VAL_W-1:0] value;
    logic                    last_pixel;
  } q_entry_t;

endpackage

@@ rtl/pcf_if.sv @@
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps

interface pcf_in_if;
  logic                                    valid;
  logic                                    ready;
  logic [pcf_pkg::REQ_W-1:0]               req_type;
  logic [pcf_pkg::CH_W-1:0]                out_channel;
  logic [pcf_pkg::CH_W-1:0]                in_channel;
  logic signed [pcf_pkg::VAL_W-1:0]        value;
  logic                                    last_pixel;

  modport source (output valid, req_type, out_channel, in_channel, value, last_pixel,
                  input ready);
  modport sink   (input valid, req_type, out_channel, in_channel, value, last_pixel,
                  output ready);
endinterface

interface pcf_out_if;
  logic                                    valid;
  logic                                    ready;
  logic [pcf_pkg::CH_W-1:0]                channel_index;
  logic signed [pcf_pkg::VAL_W-1:0]        result_value;
  logic                                    last;
  logic                                    tensor_end;

  modport source (output valid, channel_index, result_value, last, tensor_end,
                  input ready);
  modport sink   (input valid, channel_index, result_value, last, tensor_end,
                  output ready);
endinterface

@@ rtl/pcf_front.sv @@
// Front end: accept request items, drop invalid ones, classify the rest.
`timescale 1ns / 1ps

module pcf_front #(
  parameter int unsigned MAX_IN_CHANNELS  = pcf_pkg::MAX_IN_CH_DEFAULT,
  parameter int unsigned MAX_OUT_CHANNELS = pcf_pkg::MAX_OUT_CH_DEFAULT
) (
  pcf_in_if.sink                    in_if,
  input  logic [pcf_pkg::CNT_W-1:0] n_in,
  input  logic                      q_full,
  output logic                      q_push,
  output pcf_pkg::q_entry_t         q_entry
);

  logic keep;
  logic pix_ok;
  logic pix_last;

  assign in_if.ready = !q_full;

  assign pix_ok   = pcf_pkg::CNT_W'(in_if.in_channel) < n_in;
  assign pix_last = pcf_pkg::CNT_W'(in_if.in_channel) == (n_in - 7'd1);

  always_comb begin
    keep               = 1'b0;
    q_entry.op         = pcf_pkg::OP_PIXEL;
    q_entry.oc         = in_if.out_channel;
    q_entry.ic         = in_if.in_channel;
    q_entry.value      = in_if.value;
    q_entry.last_pixel = in_if.last_pixel;
    unique case (in_if.req_type)
      pcf_pkg::REQ_WEIGHT: begin
        keep       = (int'(in_if.out_channel) < MAX_OUT_CHANNELS) &&
                     (int'(in_if.in_channel) < MAX_IN_CHANNELS);
        q_entry.op = pcf_pkg::OP_WEIGHT;
      end
      pcf_pkg::REQ_BIAS: begin
        keep       = int'(in_if.out_channel) < MAX_OUT_CHANNELS;
        q_entry.op = pcf_pkg::OP_BIAS;
      end
      pcf_pkg::REQ_PIXEL: begin
        keep       = pix_ok;
        q_entry.op = pix_last ? pcf_pkg::OP_COMPUTE : pcf_pkg::OP_PIXEL;
      end
      default: begin
        keep       = 1'b0;
        q_entry.op = pcf_pkg::OP_PIXEL;
      end
    endcase
  end

  assign q_push = in_if.valid && in_if.ready && keep;

endmodule

@@ rtl/pcf_queue.sv @@
// Short FIFO of classified operations between front and back end.
`timescale 1ns / 1ps

module pcf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pcf_pkg::q_entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output pcf_pkg::q_entry_t head,
  output logic              empty
);

  localparam int unsigned DEPTH = pcf_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  pcf_pkg::q_entry_t slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = count_r == CNT_W'(DEPTH);
  assign empty   = count_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (int'(wr_ptr_r) == DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (int'(rd_ptr_r) == DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

@@ rtl/pcf_back.sv @@
// Back end: table writes, MAC pipeline per output channel, result register.
`timescale 1ns / 1ps

module pcf_back #(
  parameter int unsigned MAX_IN_CHANNELS  = pcf_pkg::MAX_IN_CH_DEFAULT,
  parameter int unsigned MAX_OUT_CHANNELS = pcf_pkg::MAX_OUT_CH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [pcf_pkg::CNT_W-1:0] n_in,
  input  logic [pcf_pkg::CNT_W-1:0] n_out,
  input  logic                      relu_en,
  input  logic                      bias_en,
  input  logic                      q_empty,
  input  pcf_pkg::q_entry_t         q_head,
  output logic                      q_pop,
  pcf_out_if.source                 out_if
);

  localparam int unsigned IN_LIMIT = (MAX_IN_CHANNELS < pcf_pkg::CH_LIMIT) ?
                                     MAX_IN_CHANNELS : pcf_pkg::CH_LIMIT;
  localparam int unsigned PIX_AW   = (IN_LIMIT > 1) ? $clog2(IN_LIMIT) : 1;
  localparam int unsigned OUT_AW   = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
  localparam int unsigned W_DEPTH  = MAX_OUT_CHANNELS * MAX_IN_CHANNELS;
  localparam int unsigned W_AW     = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
  localparam int unsigned VAL_W    = pcf_pkg::VAL_W;
  localparam int unsigned ACC_W    = pcf_pkg::ACC_W;
  localparam int unsigned SH_W     = ACC_W - pcf_pkg::FRAC_SHIFT;
  localparam logic signed [SH_W-1:0] SAT_HI = SH_W'((2 ** (pcf_pkg::DATA_WIDTH - 1)) - 1);
  localparam logic signed [SH_W-1:0] SAT_LO = -SAT_HI - 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MAC   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [VAL_W-1:0] weight_mem [W_DEPTH];
  logic signed [VAL_W-1:0] bias_mem   [MAX_OUT_CHANNELS];
  logic signed [VAL_W-1:0] pix_mem    [IN_LIMIT];

  logic [OUT_AW-1:0] o_r, o_nxt;
  logic [PIX_AW-1:0] i_r, i_nxt;
  logic              lastpix_r, lastpix_nxt;

  logic              issue, issue_first, issue_last;
  logic              o_last;
  logic [W_AW-1:0]   w_raddr;

  logic                    v1_r, first1_r, last1_r;
  logic signed [VAL_W-1:0] w_rd_r, p_rd_r, b_rd_r;
  logic                    v2_r, first2_r, last2_r;
  logic signed [pcf_pkg::PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0] base_r;
  logic signed [ACC_W-1:0] acc_r;
  logic                    acc_done_r;

  logic signed [SH_W-1:0]  shifted, clipped;
  logic                    out_free, out_load;
  logic                    out_valid_r, out_valid_nxt;
  logic [pcf_pkg::CH_W-1:0] out_chan_r;
  logic signed [VAL_W-1:0] out_res_r;
  logic                    out_last_r, out_tend_r;

  logic wr_weight, wr_bias, wr_pix;

  // Control
  assign issue       = state_r == S_MAC;
  assign issue_first = i_r == '0;
  assign issue_last  = pcf_pkg::CNT_W'(i_r) == (n_in - 7'd1);
  assign o_last      = pcf_pkg::CNT_W'(o_r) == (n_out - 7'd1);
  assign out_free    = !out_valid_r || out_if.ready;
  assign out_load    = (state_r == S_EMIT) && out_free;
  assign q_pop       = (state_r == S_IDLE) && !q_empty;

  assign wr_weight = q_pop && (q_head.op == pcf_pkg::OP_WEIGHT);
  assign wr_bias   = q_pop && (q_head.op == pcf_pkg::OP_BIAS);
  assign wr_pix    = q_pop && ((q_head.op == pcf_pkg::OP_PIXEL) ||
                               (q_head.op == pcf_pkg::OP_COMPUTE));

  always_comb begin
    state_nxt   = state_r;
    o_nxt       = o_r;
    i_nxt       = i_r;
    lastpix_nxt = lastpix_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_pop && (q_head.op == pcf_pkg::OP_COMPUTE)) begin
          state_nxt   = S_MAC;
          o_nxt       = '0;
          i_nxt       = '0;
          lastpix_nxt = q_head.last_pixel;
        end
      end
      S_MAC: begin
        if (issue_last) begin
          i_nxt     = '0;
          state_nxt = S_DRAIN;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      S_DRAIN: begin
        if (acc_done_r) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          if (o_last) begin
            o_nxt     = '0;
            state_nxt = S_IDLE;
          end else begin
            o_nxt     = o_r + 1'b1;
            state_nxt = S_MAC;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      o_r       <= '0;
      i_r       <= '0;
      lastpix_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      o_r       <= o_nxt;
      i_r       <= i_nxt;
      lastpix_r <= lastpix_nxt;
    end
  end

  // Tables
  always_ff @(posedge clk) begin
    if (wr_weight) begin
      weight_mem[W_AW'(int'(q_head.oc) * MAX_IN_CHANNELS + int'(q_head.ic))] <= q_head.value;
    end
    w_rd_r <= weight_mem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (wr_bias) begin
      bias_mem[OUT_AW'(q_head.oc)] <= q_head.value;
    end
    b_rd_r <= bias_mem[o_r];
  end

  always_ff @(posedge clk) begin
    if (wr_pix) begin
      pix_mem[PIX_AW'(q_head.ic)] <= q_head.value;
    end
    p_rd_r <= pix_mem[i_r];
  end

  assign w_raddr = W_AW'(int'(o_r) * MAX_IN_CHANNELS + int'(i_r));

  // MAC pipeline: read, multiply, accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      acc_done_r <= 1'b0;
    end else begin
      v1_r       <= issue;
      v2_r       <= v1_r;
      acc_done_r <= v2_r && last2_r;
    end
  end

  always_ff @(posedge clk) begin
    first1_r <= issue_first;
    last1_r  <= issue_last;
    first2_r <= first1_r;
    last2_r  <= last1_r;
    prod_r   <= w_rd_r * p_rd_r;
    base_r   <= bias_en ? (ACC_W'(b_rd_r) <<< pcf_pkg::FRAC_SHIFT) : '0;
    if (v2_r) begin
      acc_r <= (first2_r ? base_r : acc_r) + ACC_W'(prod_r);
    end
  end

  // Floor shift, optional ReLU, saturate
  assign shifted = acc_r[ACC_W-1:pcf_pkg::FRAC_SHIFT];

  always_comb begin
    clipped = shifted;
    if (relu_en && shifted[SH_W-1]) begin
      clipped = '0;
    end else if (shifted > SAT_HI) begin
      clipped = SAT_HI;
    end else if (shifted < SAT_LO) begin
      clipped = SAT_LO;
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_chan_r <= pcf_pkg::CH_W'(o_r);
      out_res_r  <= VAL_W'(clipped);
      out_last_r <= o_last;
      out_tend_r <= o_last && lastpix_r;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.channel_index = out_chan_r;
  assign out_if.result_value  = out_res_r;
  assign out_if.last          = out_last_r;
  assign out_if.tensor_end    = out_tend_r;

  // Checks
  a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    acc_done_r |-> state_r == S_DRAIN)
    else $error("accumulator finished outside drain");

  a_o_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> pcf_pkg::CNT_W'(o_r) < n_out)
    else $error("output channel counter beyond channel count");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC || state_r == S_DRAIN) |-> !q_pop)
    else $error("queue popped while a pixel is computed");

  a_tend_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && !o_last |=> !out_if.tensor_end)
    else $error("tensor end flagged before the last channel");

endmodule

@@ rtl/pointwise_conv_forward_core.sv @@
// Top level of the fixed-point pointwise (1x1) convolution core.
`timescale 1ns / 1ps

// Flow: an accepted item is written into the queue and popped by the back end in S_IDLE;
//   the first result of a pixel is registered after the read, multiply and accumulate stages.
// The item carrying the last input channel holds the back end until every output channel
//   is done on the single multiply-accumulate pipeline; the queue keeps taking items until full.
// Reset: rst_n is synchronous, active low; it clears the queue, sequencer and the
//   configuration (1 input, 1 output channel, ReLU and bias off). Tables hold garbage.
module pointwise_conv_forward_core #(
  parameter int unsigned MAX_IN_CHANNELS  = pcf_pkg::MAX_IN_CH_DEFAULT,
  parameter int unsigned MAX_OUT_CHANNELS = pcf_pkg::MAX_OUT_CH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  pcf_in_if.sink                         in_if,
  pcf_out_if.source                      out_if,
  input  logic                           cfg_we,
  input  logic [pcf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcf_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Pixel channels are limited by both the store depth and the 6-bit channel field.
  localparam int unsigned IN_LIMIT = (MAX_IN_CHANNELS < pcf_pkg::CH_LIMIT) ?
                                     MAX_IN_CHANNELS : pcf_pkg::CH_LIMIT;

  logic [pcf_pkg::CNT_W-1:0] in_ch_r, in_ch_nxt;
  logic [pcf_pkg::CNT_W-1:0] out_ch_r, out_ch_nxt;
  logic                      relu_r, relu_nxt;
  logic                      bias_r, bias_nxt;
  logic [pcf_pkg::CNT_W-1:0] n_in, n_out;

  logic              q_push, q_full, q_pop, q_empty;
  pcf_pkg::q_entry_t q_entry, q_head;

  // Configuration registers: the user must write them only while the core is idle; not enforced here.
  always_comb begin
    in_ch_nxt  = in_ch_r;
    out_ch_nxt = out_ch_r;
    relu_nxt   = relu_r;
    bias_nxt   = bias_r;
    if (cfg_we) begin
      unique case (cfg_index)
        pcf_pkg::CFG_IN_CHANNELS:  in_ch_nxt  = cfg_data;
        pcf_pkg::CFG_OUT_CHANNELS: out_ch_nxt = cfg_data;
        pcf_pkg::CFG_RELU_ENABLE:  relu_nxt   = cfg_data[0];
        pcf_pkg::CFG_BIAS_ENABLE:  bias_nxt   = cfg_data[0];
        default: begin
          in_ch_nxt = in_ch_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_ch_r  <= 7'd1;
      out_ch_r <= 7'd1;
      relu_r   <= 1'b0;
      bias_r   <= 1'b0;
    end else begin
      in_ch_r  <= in_ch_nxt;
      out_ch_r <= out_ch_nxt;
      relu_r   <= relu_nxt;
      bias_r   <= bias_nxt;
    end
  end

  // Effective channel counts: zero acts as one, large values clamp to the store depth.
  always_comb begin
    if (in_ch_r == '0) begin
      n_in = 7'd1;
    end else if (int'(in_ch_r) > IN_LIMIT) begin
      n_in = pcf_pkg::CNT_W'(IN_LIMIT);
    end else begin
      n_in = in_ch_r;
    end
    if (out_ch_r == '0) begin
      n_out = 7'd1;
    end else if (int'(out_ch_r) > MAX_OUT_CHANNELS) begin
      n_out = pcf_pkg::CNT_W'(MAX_OUT_CHANNELS);
    end else begin
      n_out = out_ch_r;
    end
  end

  // Front: take items, drop out-of-range and unknown ones, tag the item that closes a pixel.
  pcf_front #(
    .MAX_IN_CHANNELS  (MAX_IN_CHANNELS),
    .MAX_OUT_CHANNELS (MAX_OUT_CHANNELS)
  ) u_front (
    .in_if   (in_if),
    .n_in    (n_in),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  // Queue: lets the front keep accepting loads while the back end computes.
  pcf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty)
  );

  // Back: apply table writes in order, run the dot products, hold each result.
  pcf_back #(
    .MAX_IN_CHANNELS  (MAX_IN_CHANNELS),
    .MAX_OUT_CHANNELS (MAX_OUT_CHANNELS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .n_in    (n_in),
    .n_out   (n_out),
    .relu_en (relu_r),
    .bias_en (bias_r),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_if  (out_if)
  );

endmodule

@@ verif/pointwise_conv_forward_core_tb.sv @@
// Self-checking testbench for the pointwise 1x1 convolution core.
`timescale 1ns / 1ps

module pointwise_conv_forward_core_tb;

  // Request type with no meaning to the core; it must be dropped.
  localparam logic [pcf_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam int unsigned DRAIN_CYCLES     = 16;   // wait for the queue to retire its remaining loads
  localparam int unsigned TAIL_CYCLES      = 40;
  localparam int unsigned SQUEEZE_CYCLES   = 400;
  localparam int unsigned RANDOM_PER_PHASE = 12;
  localparam int unsigned WT_IDX_W         = 2 * pcf_pkg::CH_W;
  localparam longint      SAT_HI = longint'(2 ** (pcf_pkg::DATA_WIDTH - 1)) - 1;
  localparam longint      SAT_LO = -SAT_HI - 1;

  typedef struct {
    logic [pcf_pkg::REQ_W-1:0]        kind;
    logic [pcf_pkg::CH_W-1:0]         oc;
    logic [pcf_pkg::CH_W-1:0]         ic;
    logic signed [pcf_pkg::VAL_W-1:0] value;
    logic                             last_pixel;
  } conv_req_t;

  typedef struct {
    logic [pcf_pkg::CH_W-1:0]         channel;
    logic signed [pcf_pkg::VAL_W-1:0] value;
    logic                             last;
    logic                             tensor_end;
  } conv_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                          cfg_we;
  logic [pcf_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [pcf_pkg::CFG_DATA_W-1:0] cfg_data;

  pcf_in_if  req_bus ();
  pcf_out_if res_bus ();

  pointwise_conv_forward_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (req_bus),
    .out_if    (res_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the core: configuration, tables and the outputs it must produce.
  // ---------------------------------------------------------------------------
  logic [pcf_pkg::CNT_W-1:0]        in_ch_reg  = 7'd1;
  logic [pcf_pkg::CNT_W-1:0]        out_ch_reg = 7'd1;
  logic                             relu_on    = 1'b0;
  logic                             bias_on    = 1'b0;
  logic signed [pcf_pkg::VAL_W-1:0] weight_mem [pcf_pkg::CH_LIMIT * pcf_pkg::CH_LIMIT];
  logic signed [pcf_pkg::VAL_W-1:0] bias_mem   [pcf_pkg::CH_LIMIT];
  logic signed [pcf_pkg::VAL_W-1:0] pixel_mem  [pcf_pkg::CH_LIMIT];
  conv_result_t                     predicted_outputs [$];

  // What the request stream has written so far, so that no unwritten entry is read.
  bit wt_known   [pcf_pkg::CH_LIMIT * pcf_pkg::CH_LIMIT];
  bit bias_known [pcf_pkg::CH_LIMIT];
  bit pix_known  [pcf_pkg::CH_LIMIT];

  conv_req_t   req_queue [$];
  int unsigned useful_items = 0;
  int unsigned error_count  = 0;

  bit          squeeze_req  = 1'b0;
  bit          squeeze_done = 1'b0;
  int unsigned squeeze_left = 0;

  // A count of 0 acts as 1; anything above the table size acts as the table size.
  function automatic int unsigned clamp_count(input logic [pcf_pkg::CNT_W-1:0] v);
    if (v == 0) return 1;
    if (v > pcf_pkg::CH_LIMIT) return pcf_pkg::CH_LIMIT;
    return 32'(v);
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Extremes, full range, and a band that keeps most sums out of saturation.
  function automatic logic signed [pcf_pkg::VAL_W-1:0] rand_val();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 3))
        0: return 16'sh7FFF;
        1: return 16'sh8000;
        2: return 16'sh0000;
        default: return 16'shFFFF;
      endcase
    end
    if (r < 45) return pcf_pkg::VAL_W'($urandom);
    return pcf_pkg::VAL_W'($urandom_range(0, 2048)) - 16'sd1024;
  endfunction

  // Apply one accepted request to the shadow tables; a final channel item
  // queues one predicted result per output channel, in channel order.
  task automatic apply_conv_request(input conv_req_t rq);
    int unsigned  n_in, n_out, o, i;
    longint       acc, res;
    conv_result_t want;
    n_in  = clamp_count(in_ch_reg);
    n_out = clamp_count(out_ch_reg);
    case (rq.kind)
      pcf_pkg::REQ_WEIGHT: weight_mem[{rq.oc, rq.ic}] = rq.value;
      pcf_pkg::REQ_BIAS:   bias_mem[rq.oc] = rq.value;
      pcf_pkg::REQ_PIXEL: begin
        if (rq.ic < n_in) begin
          pixel_mem[rq.ic] = rq.value;
          if (rq.ic == n_in - 1) begin
            for (o = 0; o < n_out; o++) begin
              // Bias is Q2.14, products are Q4.28: align the bias before adding.
              acc = bias_on ?
                    (longint'(bias_mem[pcf_pkg::CH_W'(o)]) <<< pcf_pkg::FRAC_SHIFT) : 64'sd0;
              for (i = 0; i < n_in; i++)
                acc += longint'(pixel_mem[pcf_pkg::CH_W'(i)]) *
                       longint'(weight_mem[WT_IDX_W'(o * pcf_pkg::CH_LIMIT + i)]);
              res = acc >>> pcf_pkg::FRAC_SHIFT;   // floor toward minus infinity
              if (relu_on && res < 0) res = 0;
              if (res > SAT_HI) res = SAT_HI;
              else if (res < SAT_LO) res = SAT_LO;
              want.channel    = pcf_pkg::CH_W'(o);
              want.value      = res[pcf_pkg::VAL_W-1:0];
              want.last       = (o == n_out - 1);
              want.tensor_end = (o == n_out - 1) && rq.last_pixel;
              predicted_outputs.push_back(want);
            end
          end
        end
      end
      default: ;  // unknown request: dropped by the core
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers: the initial block below fills req_queue through these.
  // ---------------------------------------------------------------------------
  task automatic push_raw(input logic [pcf_pkg::REQ_W-1:0] kind,
                          input logic [pcf_pkg::CH_W-1:0] oc,
                          input logic [pcf_pkg::CH_W-1:0] ic,
                          input logic signed [pcf_pkg::VAL_W-1:0] value,
                          input logic last_pixel);
    conv_req_t rq;
    rq.kind       = kind;
    rq.oc         = oc;
    rq.ic         = ic;
    rq.value      = value;
    rq.last_pixel = last_pixel;
    req_queue.push_back(rq);
    case (kind)
      pcf_pkg::REQ_WEIGHT: begin
        wt_known[{oc, ic}] = 1'b1;
        useful_items++;
      end
      pcf_pkg::REQ_BIAS: begin
        bias_known[oc] = 1'b1;
        useful_items++;
      end
      pcf_pkg::REQ_PIXEL: begin
        if (ic < clamp_count(in_ch_reg)) begin
          pix_known[ic] = 1'b1;
          useful_items++;
        end
      end
      default: ;
    endcase
  endtask

  // Queue a request. Before an item that fires a computation, load every
  // weight, bias and pixel entry that the computation reads and that is still
  // unwritten, with random content.
  task automatic send(input logic [pcf_pkg::REQ_W-1:0] kind,
                      input logic [pcf_pkg::CH_W-1:0] oc,
                      input logic [pcf_pkg::CH_W-1:0] ic,
                      input logic signed [pcf_pkg::VAL_W-1:0] value,
                      input logic last_pixel);
    int unsigned n_in, n_out, o, i;
    n_in  = clamp_count(in_ch_reg);
    n_out = clamp_count(out_ch_reg);
    if (kind == pcf_pkg::REQ_PIXEL && ic == n_in - 1) begin
      for (o = 0; o < n_out; o++) begin
        for (i = 0; i < n_in; i++)
          if (!wt_known[WT_IDX_W'(o * pcf_pkg::CH_LIMIT + i)])
            push_raw(pcf_pkg::REQ_WEIGHT, pcf_pkg::CH_W'(o), pcf_pkg::CH_W'(i), rand_val(),
                     1'($urandom));
        if (bias_on && !bias_known[pcf_pkg::CH_W'(o)])
          push_raw(pcf_pkg::REQ_BIAS, pcf_pkg::CH_W'(o), pcf_pkg::CH_W'($urandom), rand_val(),
                   1'($urandom));
      end
      for (i = 0; i + 1 < n_in; i++)
        if (!pix_known[pcf_pkg::CH_W'(i)])
          push_raw(pcf_pkg::REQ_PIXEL, pcf_pkg::CH_W'($urandom), pcf_pkg::CH_W'(i), rand_val(),
                   1'($urandom));
    end
    push_raw(kind, oc, ic, value, last_pixel);
  endtask

  // One well-formed pixel: every input channel in order, random content.
  task automatic send_pixel(input logic final_px);
    int unsigned n_in, i;
    n_in = clamp_count(in_ch_reg);
    for (i = 0; i < n_in; i++)
      send(pcf_pkg::REQ_PIXEL, pcf_pkg::CH_W'($urandom), pcf_pkg::CH_W'(i), rand_val(),
           (i == n_in - 1) ? final_px : 1'($urandom));
  endtask

  // Hold until every request is taken, every prediction met and the line is idle.
  task automatic wait_drained();
    do @(posedge clk);
    while (req_queue.size() != 0 || req_bus.valid || predicted_outputs.size() != 0);
  endtask

  // Write all four registers while the core is idle. Loads give no result, so
  // let the internal queue retire them before touching the configuration.
  task automatic set_config(input logic [pcf_pkg::CNT_W-1:0] n_in,
                            input logic [pcf_pkg::CNT_W-1:0] n_out,
                            input logic relu, input logic bias);
    logic [pcf_pkg::CFG_IDX_W-1:0]  idx  [4];
    logic [pcf_pkg::CFG_DATA_W-1:0] data [4];
    int unsigned k;
    idx[0]  = pcf_pkg::CFG_IN_CHANNELS;
    idx[1]  = pcf_pkg::CFG_OUT_CHANNELS;
    idx[2]  = pcf_pkg::CFG_RELU_ENABLE;
    idx[3]  = pcf_pkg::CFG_BIAS_ENABLE;
    data[0] = n_in;
    data[1] = n_out;
    // Flag registers keep bit 0 only; put junk above it now and then.
    data[2] = {($urandom_range(0, 1) ? 6'($urandom) : 6'd0), relu};
    data[3] = {($urandom_range(0, 1) ? 6'($urandom) : 6'd0), bias};
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    for (k = 0; k < 4; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[2'(k)];
      cfg_data  <= data[2'(k)];
      @(posedge clk);
    end
    cfg_we     <= 1'b0;
    in_ch_reg  = n_in;
    out_ch_reg = n_out;
    relu_on    = relu;
    bias_on    = bias;
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: takes the next item from req_queue, holds it until the
  // core accepts it, then lets the shadow model apply it.
  // ---------------------------------------------------------------------------
  conv_req_t   cur_req;
  int unsigned feed_gap       = 0;
  int unsigned feed_calm_left = 0;
  bit          feed_calm      = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      req_bus.valid       <= 1'b0;
      req_bus.req_type    <= pcf_pkg::REQ_WEIGHT;
      req_bus.out_channel <= '0;
      req_bus.in_channel  <= '0;
      req_bus.value       <= '0;
      req_bus.last_pixel  <= 1'b0;
      feed_gap = 0;
    end else begin
      if (req_bus.valid && req_bus.ready) apply_conv_request(cur_req);
      // Alternate between stretches with random gaps and stretches with none.
      if (feed_calm_left == 0) begin
        feed_calm_left = $urandom_range(40, 160);
        feed_calm      = ($urandom_range(0, 3) == 0);
      end else begin
        feed_calm_left--;
      end
      // Advance only when the line is free or the current item was just taken.
      if (!req_bus.valid || req_bus.ready) begin
        if (feed_gap != 0) begin
          feed_gap--;
          req_bus.valid <= 1'b0;
        end else if (req_queue.size() != 0) begin
          cur_req = req_queue.pop_front();
          req_bus.req_type    <= cur_req.kind;
          req_bus.out_channel <= cur_req.oc;
          req_bus.in_channel  <= cur_req.ic;
          req_bus.value       <= cur_req.value;
          req_bus.last_pixel  <= cur_req.last_pixel;
          req_bus.valid       <= 1'b1;
          feed_gap = feed_calm ? 0 : pick_gap();
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: checks each accepted result against the oldest prediction
  // and drives ready with random stalls, plus one long hold-off on request.
  // ---------------------------------------------------------------------------
  int unsigned sink_gap       = 0;
  int unsigned sink_calm_left = 0;
  bit          sink_calm      = 1'b0;

  always @(posedge clk) begin : collect
    conv_result_t want;
    if (!rst_n) begin
      res_bus.ready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        if (predicted_outputs.size() == 0) begin
          $error("result for channel %0d with no prediction pending", res_bus.channel_index);
          error_count++;
        end else begin
          want = predicted_outputs.pop_front();
          if (res_bus.channel_index !== want.channel) begin
            $error("channel_index: expected %0d, got %0d", want.channel, res_bus.channel_index);
            error_count++;
          end
          if (res_bus.result_value !== want.value) begin
            $error("result_value: expected %0d, got %0d", want.value, res_bus.result_value);
            error_count++;
          end
          if (res_bus.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, res_bus.last);
            error_count++;
          end
          if (res_bus.tensor_end !== want.tensor_end) begin
            $error("tensor_end: expected %0b, got %0b", want.tensor_end, res_bus.tensor_end);
            error_count++;
          end
        end
      end
      if (sink_calm_left == 0) begin
        sink_calm_left = $urandom_range(40, 160);
        sink_calm      = ($urandom_range(0, 3) == 0);
      end else begin
        sink_calm_left--;
      end
      // The long hold-off lets the core back up into its input queue.
      if (squeeze_left != 0) begin
        squeeze_left--;
        res_bus.ready <= 1'b0;
      end else if (squeeze_req && !squeeze_done) begin
        squeeze_done = 1'b1;
        squeeze_left = SQUEEZE_CYCLES;
        res_bus.ready <= 1'b0;
      end else if (sink_gap != 0) begin
        sink_gap--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
        sink_gap = sink_calm ? 0 : pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned p, r, n_in, n_out, target;
    cfg_we    = 1'b0;
    cfg_index = pcf_pkg::CFG_IN_CHANNELS;
    cfg_data  = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, at reset configuration (one input and one output channel).
    send(pcf_pkg::REQ_WEIGHT, 6'd0, 6'd0, 16'sh7FFF, 1'b0);
    send(pcf_pkg::REQ_BIAS, 6'd0, 6'd0, 16'sh8000, 1'b0);      // bias off: must not count
    send(pcf_pkg::REQ_PIXEL, 6'd0, 6'd0, 16'sh7FFF, 1'b1);     // saturates high, ends tensor
    send(pcf_pkg::REQ_PIXEL, 6'd63, 6'd0, 16'sh8000, 1'b0);    // saturates low
    send(pcf_pkg::REQ_WEIGHT, 6'd63, 6'd63, 16'sh8000, 1'b1);
    send(pcf_pkg::REQ_WEIGHT, 6'd0, 6'd0, 16'sh8000, 1'b0);
    send(pcf_pkg::REQ_PIXEL, 6'd0, 6'd0, 16'sh8000, 1'b0);     // most negative squared
    send(pcf_pkg::REQ_PIXEL, 6'd0, 6'd0, 16'sh0000, 1'b0);
    send(pcf_pkg::REQ_PIXEL, 6'd0, 6'd0, 16'shFFFF, 1'b0);
    send(pcf_pkg::REQ_WEIGHT, 6'd0, 6'd0, 16'sh0001, 1'b0);
    send(pcf_pkg::REQ_PIXEL, 6'd0, 6'd0, 16'sh0001, 1'b0);     // tiny positive floors to zero
    send(pcf_pkg::REQ_PIXEL, 6'd0, 6'd0, 16'shFFFF, 1'b1);     // tiny negative floors to -1
    send(REQ_UNUSED, 6'd63, 6'd63, 16'shFFFF, 1'b1);           // unknown request: dropped
    send(pcf_pkg::REQ_PIXEL, 6'd0, 6'd5, 16'sh1234, 1'b1);     // beyond in_channels: dropped
    send(pcf_pkg::REQ_BIAS, 6'd63, 6'd63, 16'sh7FFF, 1'b1);

    // Directed with ReLU and bias on.
    set_config(7'd2, 7'd2, 1'b1, 1'b1);
    send(pcf_pkg::REQ_WEIGHT, 6'd0, 6'd1, 16'sh4000, 1'b0);
    send(pcf_pkg::REQ_WEIGHT, 6'd1, 6'd0, 16'shC000, 1'b0);
    send(pcf_pkg::REQ_WEIGHT, 6'd1, 6'd1, 16'sh2000, 1'b0);
    send(pcf_pkg::REQ_BIAS, 6'd0, 6'd0, -16'sd256, 1'b0);
    send(pcf_pkg::REQ_BIAS, 6'd1, 6'd0, 16'sh7FFF, 1'b0);      // big bias pushes the sum toward the top of the range
    send(pcf_pkg::REQ_PIXEL, 6'd0, 6'd0, 16'sh0100, 1'b0);
    send(pcf_pkg::REQ_PIXEL, 6'd0, 6'd1, 16'sh0100, 1'b0);
    send(pcf_pkg::REQ_PIXEL, 6'd0, 6'd1, -16'sd2048, 1'b1);    // negative sums clamp to zero

    // Channel count extremes, including out-of-range settings that clamp.
    set_config(7'd64, 7'd1, 1'b1, 1'b1);
    send_pixel(1'b0);
    send(pcf_pkg::REQ_PIXEL, 6'd0, 6'd63, 16'sh8000, 1'b1);    // refire, only last channel new
    set_config(7'd127, 7'd0, 1'b0, 1'b0);                      // acts as 64 in, 1 out
    send(pcf_pkg::REQ_PIXEL, 6'd17, 6'd63, rand_val(), 1'b1);
    set_config(7'd0, 7'd100, 1'b1, 1'b0);                      // acts as 1 in, 64 out
    send_pixel(1'b1);

    // Random phases: mostly whole pixels, the rest loads, lone channels and noise.
    for (p = 0; p < 4; p++) begin
      if (p == 0)
        set_config(7'($urandom_range(1, 2)), 7'($urandom_range(3, 6)),
                   1'($urandom), 1'($urandom));
      else
        set_config(7'($urandom_range(1, (p == 2) ? 8 : 4)),
                   7'($urandom_range(1, (p == 3) ? 8 : 4)), 1'($urandom), 1'($urandom));
      // First random phase: stall the result side for a long stretch.
      if (p == 0) squeeze_req = 1'b1;
      n_in   = clamp_count(in_ch_reg);
      n_out  = clamp_count(out_ch_reg);
      target = useful_items + RANDOM_PER_PHASE;
      while (useful_items < target) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          send_pixel($urandom_range(0, 3) == 0);
        end else if (r < 68) begin
          if ($urandom_range(0, 9) < 7)
            send(pcf_pkg::REQ_WEIGHT, pcf_pkg::CH_W'($urandom_range(0, n_out - 1)),
                 pcf_pkg::CH_W'($urandom_range(0, n_in - 1)), rand_val(), 1'($urandom));
          else
            send(pcf_pkg::REQ_WEIGHT, pcf_pkg::CH_W'($urandom), pcf_pkg::CH_W'($urandom),
                 rand_val(), 1'($urandom));
        end else if (r < 76) begin
          send(pcf_pkg::REQ_BIAS, pcf_pkg::CH_W'($urandom), pcf_pkg::CH_W'($urandom),
               rand_val(), 1'($urandom));
        end else if (r < 84) begin
          // Lone channel, possibly the last one: a broken pixel sequence.
          send(pcf_pkg::REQ_PIXEL, pcf_pkg::CH_W'($urandom),
               pcf_pkg::CH_W'($urandom_range(0, n_in - 1)), rand_val(), 1'($urandom));
        end else if (r < 92) begin
          send(pcf_pkg::REQ_PIXEL, pcf_pkg::CH_W'($urandom),
               pcf_pkg::CH_W'($urandom_range(n_in, pcf_pkg::CH_LIMIT - 1)),
               rand_val(), 1'($urandom));
        end else begin
          send(REQ_UNUSED, pcf_pkg::CH_W'($urandom), pcf_pkg::CH_W'($urandom),
               rand_val(), 1'($urandom));
        end
      end
    end

    // Drain, then give a stray result time to show up.
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

@@ pointwise_conv_forward_core.f @@
rtl/pcf_pkg.sv
rtl/pcf_if.sv
rtl/pcf_front.sv
rtl/pcf_queue.sv
rtl/pcf_back.sv
rtl/pointwise_conv_forward_core.sv
verif/pointwise_conv_forward_core_tb.sv
